FILE: hdl/chacha20_block_function_assert.svh
// Assertion macros shared by the keystream pipeline.
// Both expect clk and rst_n to be visible where they are used.
`ifndef CHACHA20_BLOCK_FUNCTION_ASSERT_SVH
`define CHACHA20_BLOCK_FUNCTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cc20 check failed");

// The consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cc20 check failed");

`endif

FILE: hdl/cc20_pkg.sv
package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int STEPS_PER_DR  = 8;
    localparam int CELLS         = DOUBLE_ROUNDS * STEPS_PER_DR;
    localparam int WORDS         = 16;

    typedef logic [31:0] word_t;
    typedef word_t [WORDS-1:0] state_t;
    typedef logic [2:0] step_t;
    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t CFG_KEY_0_1   = 3'd0;
    localparam cfg_idx_t CFG_KEY_2_3   = 3'd1;
    localparam cfg_idx_t CFG_KEY_4_5   = 3'd2;
    localparam cfg_idx_t CFG_KEY_6_7   = 3'd3;
    localparam cfg_idx_t CFG_NONCE_0_1 = 3'd4;
    localparam cfg_idx_t CFG_NONCE_2   = 3'd5;

    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    typedef struct packed {
        logic [63:0] key_0_1;
        logic [63:0] key_2_3;
        logic [63:0] key_4_5;
        logic [63:0] key_6_7;
        logic [63:0] nonce_0_1;
        word_t       nonce_2;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        word_t  ctr;
        state_t st;
    } lane_t;

    // Rotate left by 16, 12, 8 or 7, in the order the quarter round uses them.
    function automatic word_t rotl(word_t x, logic [1:0] sel);
        word_t r;
        case (sel)
            2'd0:    r = {x[15:0], x[31:16]};
            2'd1:    r = {x[19:0], x[31:20]};
            2'd2:    r = {x[23:0], x[31:24]};
            2'd3:    r = {x[24:0], x[31:25]};
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic state_t build_state(cfg_t c, word_t ctr);
        state_t s;
        s[0]  = SIGMA_0;
        s[1]  = SIGMA_1;
        s[2]  = SIGMA_2;
        s[3]  = SIGMA_3;
        s[4]  = c.key_0_1[31:0];
        s[5]  = c.key_0_1[63:32];
        s[6]  = c.key_2_3[31:0];
        s[7]  = c.key_2_3[63:32];
        s[8]  = c.key_4_5[31:0];
        s[9]  = c.key_4_5[63:32];
        s[10] = c.key_6_7[31:0];
        s[11] = c.key_6_7[63:32];
        s[12] = ctr;
        s[13] = c.nonce_0_1[31:0];
        s[14] = c.nonce_0_1[63:32];
        s[15] = c.nonce_2;
        return s;
    endfunction

endpackage

FILE: hdl/cc20_ifs.sv
interface cc20_ctr_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          block_counter;

    modport source (output valid, output block_counter, input ready);
    modport sink   (input valid, input block_counter, output ready);
endinterface

interface cc20_ks_if;
    logic        valid;
    logic        ready;
    logic [63:0] stream_words_0_1;
    logic [63:0] stream_words_2_3;
    logic [63:0] stream_words_4_5;
    logic [63:0] stream_words_6_7;
    logic [63:0] stream_words_8_9;
    logic [63:0] stream_words_10_11;
    logic [63:0] stream_words_12_13;
    logic [63:0] stream_words_14_15;

    modport source (
        output valid, input ready,
        output stream_words_0_1, output stream_words_2_3,
        output stream_words_4_5, output stream_words_6_7,
        output stream_words_8_9, output stream_words_10_11,
        output stream_words_12_13, output stream_words_14_15
    );
    modport sink (
        input valid, output ready,
        input stream_words_0_1, input stream_words_2_3,
        input stream_words_4_5, input stream_words_6_7,
        input stream_words_8_9, input stream_words_10_11,
        input stream_words_12_13, input stream_words_14_15
    );
endinterface

FILE: hdl/cc20_cell.sv
`include "chacha20_block_function_assert.svh"

// One add-xor-rotate step of all four quarter rounds of a half double round.
// step[2] picks column or diagonal, step[1:0] picks which of the four steps.
module cc20_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  cc20_pkg::step_t step,
    input  cc20_pkg::lane_t up,
    output logic            up_ready,
    output cc20_pkg::lane_t dn,
    input  logic            dn_ready
);

    logic            valid_reg, valid_next;
    cc20_pkg::word_t ctr_reg;
    cc20_pkg::state_t st_reg, st_next;

    always_comb
    begin
        logic [1:0]      qq, ob, oc, od;
        logic [3:0]      ia, ib, ic, id, ix, iy, iz;
        cc20_pkg::word_t sum;
        st_next = up.st;
        for (int q = 0; q < 4; q++)
        begin
            qq = q[1:0];
            ob = step[2] ? qq + 2'd1 : qq;
            oc = step[2] ? qq + 2'd2 : qq;
            od = step[2] ? qq + 2'd3 : qq;
            ia = {2'b00, qq};
            ib = {2'b01, ob};
            ic = {2'b10, oc};
            id = {2'b11, od};
            // Even steps update a and d, odd steps update c and b.
            ix = step[0] ? ic : ia;
            iy = step[0] ? id : ib;
            iz = step[0] ? ib : id;
            sum = st_next[ix] + st_next[iy];
            st_next[ix] = sum;
            st_next[iz] = cc20_pkg::rotl(st_next[iz] ^ sum, step[1:0]);
        end
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            ctr_reg <= up.ctr;
            st_reg  <= st_next;
        end
    end

    assign dn.valid = valid_reg;
    assign dn.ctr   = ctr_reg;
    assign dn.st    = st_reg;

    `CC20_ASSERT_NOW(a_empty_takes, !valid_reg, up_ready)
    `CC20_ASSERT_NEXT(a_load_fills, up.valid && up_ready, valid_reg)
    `CC20_ASSERT_NEXT(a_stall_holds, valid_reg && !dn_ready,
                      valid_reg && $stable(ctr_reg) && $stable(st_reg))
    `CC20_ASSERT_NEXT(a_drain_empties, valid_reg && dn_ready && !up.valid, !valid_reg)

endmodule

FILE: hdl/cc20_out.sv
// Adds the initial state back in and holds the finished keystream item
// until the sink takes it.
module cc20_out (
    input  logic            clk,
    input  logic            rst_n,
    input  cc20_pkg::cfg_t  cfg,
    input  cc20_pkg::lane_t up,
    output logic            up_ready,
    cc20_ks_if.source       ks
);

    logic             valid_reg, valid_next;
    cc20_pkg::state_t ks_reg, ks_next, init;

    assign init = cc20_pkg::build_state(cfg, up.ctr);

    always_comb
    begin
        for (int i = 0; i < cc20_pkg::WORDS; i++)
        begin
            ks_next[i] = up.st[i] + init[i];
        end
    end

    assign up_ready   = !valid_reg || ks.ready;
    assign valid_next = up_ready ? up.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            ks_reg <= ks_next;
        end
    end

    assign ks.valid              = valid_reg;
    assign ks.stream_words_0_1   = {ks_reg[1],  ks_reg[0]};
    assign ks.stream_words_2_3   = {ks_reg[3],  ks_reg[2]};
    assign ks.stream_words_4_5   = {ks_reg[5],  ks_reg[4]};
    assign ks.stream_words_6_7   = {ks_reg[7],  ks_reg[6]};
    assign ks.stream_words_8_9   = {ks_reg[9],  ks_reg[8]};
    assign ks.stream_words_10_11 = {ks_reg[11], ks_reg[10]};
    assign ks.stream_words_12_13 = {ks_reg[13], ks_reg[12]};
    assign ks.stream_words_14_15 = {ks_reg[15], ks_reg[14]};

endmodule

FILE: hdl/chacha20_block_function.sv
// Pipeline: an accepted counter item passes through the 80 round-step cells
// (8 per double round) and then through the output register that adds the
// initial state back in, and leaves it as a keystream item.
// Throughput: one item per cycle; a stall only backs up through full cells.
// Reset: rst_n clears all valid bits and sets key and nonce to zero.
module chacha20_block_function (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    cc20_ctr_if.sink    ctr_ch,
    cc20_ks_if.source   ks_ch
);

    cc20_pkg::cfg_t  cfg_reg, cfg_next;
    cc20_pkg::lane_t lanes [0:cc20_pkg::CELLS];
    logic            rdy   [0:cc20_pkg::CELLS];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cc20_pkg::CFG_KEY_0_1:   cfg_next.key_0_1   = cfg_data;
                cc20_pkg::CFG_KEY_2_3:   cfg_next.key_2_3   = cfg_data;
                cc20_pkg::CFG_KEY_4_5:   cfg_next.key_4_5   = cfg_data;
                cc20_pkg::CFG_KEY_6_7:   cfg_next.key_6_7   = cfg_data;
                cc20_pkg::CFG_NONCE_0_1: cfg_next.nonce_0_1 = cfg_data;
                cc20_pkg::CFG_NONCE_2:   cfg_next.nonce_2   = cfg_data[31:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign lanes[0].valid = ctr_ch.valid;
    assign lanes[0].ctr   = ctr_ch.block_counter;
    assign lanes[0].st    = cc20_pkg::build_state(cfg_reg, ctr_ch.block_counter);
    assign ctr_ch.ready   = rdy[0];

    for (genvar g = 0; g < cc20_pkg::CELLS; g++)
    begin : g_cell
        cc20_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (cc20_pkg::step_t'(g % cc20_pkg::STEPS_PER_DR)),
            .up       (lanes[g]),
            .up_ready (rdy[g]),
            .dn       (lanes[g+1]),
            .dn_ready (rdy[g+1])
        );
    end

    cc20_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up       (lanes[cc20_pkg::CELLS]),
        .up_ready (rdy[cc20_pkg::CELLS]),
        .ks       (ks_ch)
    );

endmodule
